FILE: src/mpoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoa_pkg
// Shared constants and payload types of the mask pair overlap analyzer.
// ----------------------------------------------------------------------------
package mpoa_pkg;

    localparam int MAX_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int BIT_IDX_W = 6;
    localparam int POS_W     = $clog2(MAX_WORDS + 1);
    localparam int FIRST_W   = $clog2(MAX_WORDS * WORD_W);
    localparam int END_W     = $clog2(MAX_WORDS * WORD_W + 1);
    localparam int PCNT_W    = $clog2(WORD_W + 1);

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic              end_of_mask;
    } t_in_item;

    typedef struct packed {
        logic       any_common;
        logic [7:0] first_point;
        logic [8:0] end_point;
        logic [8:0] common_count;
        logic       dense_flag;
        logic       overrun;
    } t_out_item;

    function automatic logic [PCNT_W-1:0] f_popcount(input logic [WORD_W-1:0] v);
        logic [PCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + PCNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] f_lowest(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] f_highest(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/mpoa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoa_in_if
// Valid/ready channel carrying one mask word pair per transfer.
// ----------------------------------------------------------------------------
interface mpoa_in_if import mpoa_pkg::*; ();

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: src/mpoa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoa_out_if
// Valid/ready channel carrying one overlap result per transfer.
// ----------------------------------------------------------------------------
interface mpoa_out_if import mpoa_pkg::*; ();

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: src/mask_pair_overlap_analyzer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_pair_overlap_analyzer
// Streams two bitmasks as 64-bit word pairs and reports where they overlap.
// ----------------------------------------------------------------------------
// Accepts one word pair per cycle, lowest word first, with a flag on the
// final pair of a mask. Each pair is captured in an input register, ANDed,
// popcounted and priority-encoded, and folded into the running state. The
// final pair loads the result register, so a result follows its last pair
// through the input register and then the result register. Pairs beyond
// MAX_WORDS are dropped and set the overrun flag. Input stalls only when a
// final pair waits behind an unread result.
module mask_pair_overlap_analyzer import mpoa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpoa_in_if.sink    i_item,
    mpoa_out_if.source o_result
);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_last;

    logic [POS_W-1:0]   r_pos;
    logic               r_seen;
    logic [FIRST_W-1:0] r_first;
    logic [END_W-1:0]   r_end;
    logic [END_W-1:0]   r_count;
    logic               r_ovr;

    logic      r_out_valid;
    t_out_item r_out;

    logic [POS_W-1:0]   n_pos;
    logic               n_seen;
    logic [FIRST_W-1:0] n_first;
    logic [END_W-1:0]   n_end;
    logic [END_W-1:0]   n_count;
    logic               n_ovr;
    logic               n_dense;

    logic [WORD_W-1:0] both;
    logic              in_range;
    logic              hit;
    logic              out_free;
    logic              adv;
    logic [END_W-1:0]  span;

    assign out_free     = !r_out_valid || o_result.ready;
    assign adv          = r_s1_valid && (!r_last || out_free);
    assign i_item.ready = !r_s1_valid || adv;

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // per-word update
    always_comb begin
        both     = r_a & r_b;
        in_range = r_pos < POS_W'(MAX_WORDS);
        hit      = in_range && (|both);
        n_pos    = in_range ? r_pos + POS_W'(1) : r_pos;
        n_ovr    = r_ovr || !in_range;
        n_seen   = r_seen || hit;
        n_count  = hit ? r_count + END_W'(f_popcount(both)) : r_count;
        n_first  = (hit && !r_seen)
                 ? ((FIRST_W'(r_pos) << BIT_IDX_W) + FIRST_W'(f_lowest(both)))
                 : r_first;
        n_end    = hit
                 ? ((END_W'(r_pos) << BIT_IDX_W) + END_W'(f_highest(both)) + END_W'(1))
                 : r_end;
        span     = n_end - END_W'(n_first);
        n_dense  = n_seen && (n_count > (span >> 2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_a    <= i_item.data.word_a;
            r_b    <= i_item.data.word_b;
            r_last <= i_item.data.end_of_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_first <= '0;
            r_end   <= '0;
            r_count <= '0;
            r_ovr   <= 1'b0;
        end else if (adv) begin
            r_pos   <= n_pos;
            r_seen  <= n_seen;
            r_first <= n_first;
            r_end   <= n_end;
            r_count <= n_count;
            r_ovr   <= n_ovr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last) begin
            r_out.any_common   <= n_seen;
            r_out.first_point  <= 8'(n_first);
            r_out.end_point    <= 9'(n_end);
            r_out.common_count <= 9'(n_count);
            r_out.dense_flag   <= n_dense;
            r_out.overrun      <= n_ovr;
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    a_no_overlap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.data.any_common |->
            o_result.data.first_point == 8'd0 && o_result.data.end_point == 9'd0 &&
            o_result.data.common_count == 9'd0 && !o_result.data.dense_flag)
        else $error("nonzero fields without overlap");

    a_state_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> r_end > END_W'(r_first) && r_count != '0)
        else $error("overlap state inconsistent");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_last && r_out_valid && !o_result.ready |=> r_s1_valid && r_last)
        else $error("final pair lost while result stalled");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovr |=> r_pos <= POS_W'(MAX_WORDS))
        else $error("word position past limit");

endmodule

FILE: tb/mpoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoa_checker
// Watches both channels of the mask pair overlap analyzer and checks results.
// ----------------------------------------------------------------------------
// Folds every accepted word pair into its own copy of the overlap state and,
// on the final pair of a mask, queues the overlap result it expects. Each
// accepted result is compared field by field with the oldest queued one.
// Hands the failure count, the number of results still owed and the number
// of results checked to the testbench top.
module mpoa_checker import mpoa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mpoa_in_if   i_item,
    mpoa_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    int unsigned words_taken   = 0;
    logic        hit_seen      = 1'b0;
    int unsigned first_bit     = 0;
    int unsigned end_bit       = 0;
    int unsigned overlap_bits  = 0;
    logic        overflowed    = 1'b0;

    t_out_item   owed_overlaps[$];
    t_out_item   want;
    t_out_item   seen_res;
    int          fail_total    = 0;
    int          shown         = 0;
    int          results_done  = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = results_done;

    task automatic clear_overlap_state();
        words_taken  = 0;
        hit_seen     = 1'b0;
        first_bit    = 0;
        end_bit      = 0;
        overlap_bits = 0;
        overflowed   = 1'b0;
    endtask

    task automatic fold_word_pair(input t_in_item pair);
        logic [WORD_W-1:0] both;
        logic              got;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       fp;
        int unsigned       ep;
        int unsigned       cnt;
        int unsigned       span;
        t_out_item         res;
        if (words_taken >= MAX_WORDS) begin
            overflowed = 1'b1;
        end else begin
            both = pair.word_a & pair.word_b;
            if (both != '0) begin
                got = 1'b0;
                lo  = 0;
                hi  = 0;
                for (int i = 0; i < WORD_W; i++) begin
                    if (both[i]) begin
                        if (!got) begin
                            lo = i;
                        end
                        got = 1'b1;
                        hi  = i;
                    end
                end
                overlap_bits += $countones(both);
                if (!hit_seen) begin
                    first_bit = words_taken * WORD_W + lo;
                    hit_seen  = 1'b1;
                end
                end_bit = words_taken * WORD_W + hi + 1;
            end
            words_taken++;
        end
        if (pair.end_of_mask) begin
            fp   = hit_seen ? first_bit : 0;
            ep   = hit_seen ? end_bit : 0;
            cnt  = hit_seen ? overlap_bits : 0;
            span = (ep >= fp) ? ep - fp : 0;
            res.any_common   = hit_seen;
            res.first_point  = fp[7:0];
            res.end_point    = ep[8:0];
            res.common_count = cnt[8:0];
            res.dense_flag   = hit_seen && (cnt > span / 4);
            res.overrun      = overflowed;
            owed_overlaps.push_back(res);
            clear_overlap_state();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_overlap_state();
            owed_overlaps.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                seen_res = i_result.data;
                if (owed_overlaps.size() == 0) begin
                    fail_total++;
                    if (shown < 10) begin
                        $display("extra result hit=%0b fp=%0d ep=%0d cnt=%0d dn=%0b ov=%0b",
                                 seen_res.any_common, seen_res.first_point,
                                 seen_res.end_point, seen_res.common_count,
                                 seen_res.dense_flag, seen_res.overrun);
                    end
                    shown++;
                end else begin
                    want = owed_overlaps.pop_front();
                    results_done++;
                    if (seen_res.any_common   !== want.any_common   ||
                        seen_res.first_point  !== want.first_point  ||
                        seen_res.end_point    !== want.end_point    ||
                        seen_res.common_count !== want.common_count ||
                        seen_res.dense_flag   !== want.dense_flag   ||
                        seen_res.overrun      !== want.overrun) begin
                        fail_total++;
                        if (shown < 10) begin
                            $display("result %0d mismatch at %0t", results_done, $realtime);
                            $display("  exp hit=%0b fp=%0d ep=%0d cnt=%0d dn=%0b ov=%0b",
                                     want.any_common, want.first_point, want.end_point,
                                     want.common_count, want.dense_flag, want.overrun);
                            $display("  got hit=%0b fp=%0d ep=%0d cnt=%0d dn=%0b ov=%0b",
                                     seen_res.any_common, seen_res.first_point,
                                     seen_res.end_point, seen_res.common_count,
                                     seen_res.dense_flag, seen_res.overrun);
                        end
                        shown++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                fold_word_pair(i_item.data);
            end
        end
        o_pending <= owed_overlaps.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the mask pair overlap analyzer.
// ----------------------------------------------------------------------------
// Sends a short set of hand-built masks (full overlap, no overlap, topmost
// point only, too many words, density boundary), then phases of random masks
// with varying overlap patterns and lengths, some past MAX_WORDS. Both sides
// idle at random, with burst phases, one long result hold-off and a drain
// between phases. The checker predicts and compares; this module reports.
module tb_top;

    import mpoa_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PAIRS   = 680;
    localparam int PHASES         = 5;
    localparam logic [WORD_W-1:0] ODD_BITS  = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] EVEN_BITS = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [WORD_W-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;

    logic clk = 1'b0;
    logic rst_n;

    bit   src_burst    = 1'b0;
    bit   snk_burst    = 1'b0;
    bit   hold_results = 1'b0;
    int   pairs_sent    = 0;
    int   useful_pairs  = 0;
    int   masks_sent    = 0;
    int   overrun_masks = 0;
    int   mask_pos      = 0;
    int   fail_total;
    int   pending;
    int   results_checked;

    mpoa_in_if  in_ch ();
    mpoa_out_if out_ch ();

    mask_pair_overlap_analyzer dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    mpoa_checker overlap_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_total),
        .o_pending    (pending),
        .o_checked    (results_checked)
    );

    always #2 clk = ~clk;

    task automatic send_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                             input logic last);
        int       gap;
        t_in_item pair;
        gap = src_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair.word_a      = a;
        pair.word_b      = b;
        pair.end_of_mask = last;
        in_ch.valid <= 1'b1;
        in_ch.data  <= pair;
        do @(posedge clk); while (!in_ch.ready);
        pairs_sent++;
        if (mask_pos < MAX_WORDS) begin
            useful_pairs++;
        end
        mask_pos++;
        if (last) begin
            masks_sent++;
            if (mask_pos > MAX_WORDS) begin
                overrun_masks++;
            end
            mask_pos = 0;
        end
    endtask

    task automatic send_mask(input int n_words, input bit sparse);
        logic [WORD_W-1:0] common;
        logic [WORD_W-1:0] r1;
        logic [WORD_W-1:0] r2;
        logic [WORD_W-1:0] r3;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        for (int w = 0; w < n_words; w++) begin
            r1 = {$urandom, $urandom};
            r2 = {$urandom, $urandom};
            r3 = {$urandom, $urandom};
            if (sparse) begin
                common = ($urandom_range(0, 7) == 0) ? (64'h1 << $urandom_range(0, 63)) : '0;
            end else begin
                case ($urandom_range(0, 5))
                    0: common = '0;
                    1: common = '1;
                    2: common = 64'h1 << $urandom_range(0, 63);
                    3: common = r3 & {$urandom, $urandom} & {$urandom, $urandom};
                    4: common = ('1 << $urandom_range(0, 63)) & ('1 >> $urandom_range(0, 63));
                    default: common = r3;
                endcase
            end
            case ($urandom_range(0, 7))
                0: begin
                    a = common;
                    b = common;
                end
                1, 2: begin
                    a = r1;
                    b = r2;
                end
                default: begin
                    // and of the two words is exactly the chosen common bits
                    a = common | r1;
                    b = common | (r2 & ~r1);
                end
            endcase
            send_pair(a, b, w == n_words - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_results) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            stall = snk_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int goal;
        int n_words;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full overlap in a single word
        send_pair('1, '1, 1'b1);
        // disjoint masks
        send_pair(ODD_BITS, EVEN_BITS, 1'b1);
        // every point common, largest count
        for (int w = 0; w < MAX_WORDS; w++) begin
            send_pair('1, '1, w == MAX_WORDS - 1);
        end
        // only the topmost point common
        for (int w = 0; w < MAX_WORDS - 1; w++) begin
            send_pair(ODD_BITS, EVEN_BITS, 1'b0);
        end
        send_pair(TOP_BIT, '1, 1'b1);
        // too many words, the ignored pair overlaps fully
        send_pair(64'h1, 64'h1, 1'b0);
        for (int w = 1; w < MAX_WORDS; w++) begin
            send_pair('1, '0, 1'b0);
        end
        send_pair('1, '1, 1'b1);
        // sparse hits in middle words, last word empty
        send_pair('0, '1, 1'b0);
        send_pair(64'h1, '1, 1'b0);
        send_pair(TOP_BIT, TOP_BIT, 1'b0);
        send_pair(EVEN_BITS, ODD_BITS, 1'b1);
        // count equal to a quarter of the span rounded down, not dense
        send_pair(64'h101, 64'h101, 1'b1);
        // single point, dense
        send_pair(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1);
        // early hit, empty final word
        send_pair(64'hF0, 64'h3C, 1'b0);
        send_pair('0, '0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            src_burst = (phase == 1) || (phase == 3);
            snk_burst = (phase == 2) || (phase == 3);
            if (phase == 3) begin
                hold_results = 1'b1;
            end
            goal = useful_pairs + RANDOM_PAIRS / PHASES;
            while (useful_pairs < goal) begin
                n_words = ($urandom_range(0, 9) == 0) ?
                          $urandom_range(MAX_WORDS + 1, MAX_WORDS + 3) :
                          $urandom_range(1, MAX_WORDS);
                send_mask(n_words, $urandom_range(0, 4) == 0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d word pairs in %0d masks, %0d of them past the word limit",
                 pairs_sent, masks_sent, overrun_masks);
        $display("checked %0d overlap results, %0d failures", results_checked, fail_total);
        if (fail_total == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
